// ===== hdl/tirr_pkg.sv =====
// ----------------------------------------------------------------------------
// tirr_pkg
// Shared types and constants of the timed input record and replay block.
// ----------------------------------------------------------------------------
package tirr_pkg;

    // default sizes
    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_TIME_BITS   = 32;

    // fixed field widths
    localparam int KEY_W       = 16;
    localparam int DEV_W       = 5;
    localparam int STROKE_W    = 64;
    localparam int COUNT_OUT_W = 11;

    // register reset values
    localparam logic [KEY_W-1:0] RESET_RECORD_KEY = 16'h003B;
    localparam logic [KEY_W-1:0] RESET_REPLAY_KEY = 16'h003C;

    // register indexes
    localparam logic CFG_RECORD_KEY = 1'b0;
    localparam logic CFG_REPLAY_KEY = 1'b1;

    // request kinds
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_STROKE = 1'b1;

    // result source
    localparam logic SRC_LIVE   = 1'b0;
    localparam logic SRC_REPLAY = 1'b1;

    // run mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } mode_t;

endpackage

// ===== hdl/timed_input_record_replay_top.sv =====
// ----------------------------------------------------------------------------
// timed_input_record_replay_top
// Records input strokes with tick stamps and replays them with their gaps.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------
//  config    cfg_we                 cfg_index, cfg_data
//  input     in_valid / in_ready    action, device, is_keyboard, stroke_word
//  output    out_valid / out_ready  send_*, mode, toggle_rejected,
//                                   record_count, record_dropped
//
//  One request per cycle; its result sits in the output register in the
//  cycle after acceptance. The store memories have registered reads, done
//  every cycle at the next replay pointer (and the entry after it), so the
//  entry data and the gap are ready when the next tick arrives. Reset clears
//  mode, counters and out_valid; payload and store contents are left as
//  they are. A stalled output holds in_ready low only while full.
//
module timed_input_record_replay_top
    import tirr_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [KEY_W-1:0]       cfg_data,
    // input requests
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [DEV_W-1:0]       device,
    input  logic                   is_keyboard,
    input  logic [STROKE_W-1:0]    stroke_word,
    // results
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   send_valid,
    output logic                   send_source,
    output logic [DEV_W-1:0]       send_device,
    output logic [STROKE_W-1:0]    send_stroke,
    output logic [1:0]             mode,
    output logic                   toggle_rejected,
    output logic [COUNT_OUT_W-1:0] record_count,
    output logic                   record_dropped
);

    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // configuration registers
    logic [KEY_W-1:0] rec_key_reg;
    logic [KEY_W-1:0] play_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_key_reg  <= RESET_RECORD_KEY;
            play_key_reg <= RESET_REPLAY_KEY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RECORD_KEY: rec_key_reg  <= cfg_data;
                CFG_REPLAY_KEY: play_key_reg <= cfg_data;
                default:        rec_key_reg  <= rec_key_reg;
            endcase
        end
    end

    // control state
    mode_t                mode_reg, mode_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [TIME_BITS-1:0] wait_reg, wait_next;
    logic                 pend_reg, pend_next;

    // store memories and their read registers
    logic [DEV_W-1:0]     dev_mem    [STORE_DEPTH];
    logic [STROKE_W-1:0]  stroke_mem [STORE_DEPTH];
    logic [TIME_BITS-1:0] time_mem   [STORE_DEPTH];
    logic [DEV_W-1:0]     rd_dev;
    logic [STROKE_W-1:0]  rd_stroke;
    logic [TIME_BITS-1:0] rd_time_cur;
    logic [TIME_BITS-1:0] rd_time_nxt;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   snd_valid_reg, snd_valid_next;
    logic                   snd_src_reg, snd_src_next;
    logic [DEV_W-1:0]       snd_dev_reg, snd_dev_next;
    logic [STROKE_W-1:0]    snd_stroke_reg, snd_stroke_next;
    logic                   rejected_reg, rejected_next;
    logic                   dropped_reg, dropped_next;
    logic [1:0]             mode_out_reg;
    logic [CNT_W-1:0]       count_out_reg;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    // request decode
    logic             in_fire;
    logic             is_tick;
    logic             key_down;
    logic             is_rec_key;
    logic             is_play_key;
    logic             wr_en;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] ptr_next_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_tick  = (action == ACT_TICK);
    assign key_down = (stroke_word[31:16] == 16'h0000);

    // record key wins when both codes are equal
    assign is_rec_key  = (action == ACT_STROKE) && is_keyboard && key_down
                         && (stroke_word[15:0] == rec_key_reg);
    assign is_play_key = (action == ACT_STROKE) && is_keyboard && key_down
                         && !is_rec_key && (stroke_word[15:0] == play_key_reg);

    assign wr_en = in_fire && (action == ACT_STROKE) && !is_rec_key && !is_play_key
                   && (mode_reg == MODE_REC) && (count_reg < DEPTH_C);

    assign ptr_inc      = ptr_reg + ONE_C;
    assign ptr_next_inc = ptr_next + ONE_C;

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (in_fire && is_rec_key)
        begin
            case (mode_reg)
                MODE_IDLE: mode_next = MODE_REC;
                MODE_REC:  mode_next = MODE_IDLE;
                default:   mode_next = mode_reg;
            endcase
        end
        else if (in_fire && is_play_key)
        begin
            case (mode_reg)
                MODE_IDLE: mode_next = MODE_PLAY;
                MODE_PLAY: mode_next = MODE_IDLE;
                default:   mode_next = mode_reg;
            endcase
        end
    end

    // counters, replay timing and result fields
    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        tick_next       = tick_reg;
        wait_next       = wait_reg;
        pend_next       = pend_reg;
        snd_valid_next  = 1'b0;
        snd_src_next    = SRC_LIVE;
        snd_dev_next    = '0;
        snd_stroke_next = '0;
        rejected_next   = 1'b0;
        dropped_next    = 1'b0;

        if (in_fire)
        begin
            if (is_tick)
            begin
                tick_next = tick_reg + TIME_BITS'(1);
                if (mode_reg == MODE_PLAY)
                begin
                    // count down the pending gap
                    if (pend_reg)
                    begin
                        if (wait_reg == '0)
                            pend_next = 1'b0;
                        else
                            wait_next = wait_reg - TIME_BITS'(1);
                    end
                    // send the entry at the pointer
                    if (!pend_next && (ptr_reg < count_reg))
                    begin
                        snd_valid_next  = 1'b1;
                        snd_src_next    = SRC_REPLAY;
                        snd_dev_next    = rd_dev;
                        snd_stroke_next = rd_stroke;
                        ptr_next        = ptr_inc;
                        if (ptr_inc < count_reg)
                        begin
                            wait_next = rd_time_nxt - rd_time_cur;
                            pend_next = 1'b1;
                        end
                    end
                end
            end
            else if (is_rec_key)
            begin
                if (mode_reg == MODE_IDLE)
                    count_next = '0;
                else if (mode_reg == MODE_PLAY)
                    rejected_next = 1'b1;
            end
            else if (is_play_key)
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    wait_next = '0;
                end
                else if (mode_reg == MODE_PLAY)
                begin
                    pend_next = 1'b0;
                    wait_next = '0;
                end
                else
                    rejected_next = 1'b1;
            end
            else
            begin
                // ordinary stroke
                if (mode_reg == MODE_REC)
                begin
                    if (count_reg < DEPTH_C)
                        count_next = count_reg + ONE_C;
                    else
                        dropped_next = 1'b1;
                end
                if (mode_reg != MODE_PLAY)
                begin
                    snd_valid_next  = 1'b1;
                    snd_src_next    = SRC_LIVE;
                    snd_dev_next    = device;
                    snd_stroke_next = stroke_word;
                end
            end
        end
    end

    assign out_valid_next = in_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            tick_reg      <= '0;
            wait_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            tick_reg      <= tick_next;
            wait_reg      <= wait_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            snd_valid_reg  <= snd_valid_next;
            snd_src_reg    <= snd_src_next;
            snd_dev_reg    <= snd_dev_next;
            snd_stroke_reg <= snd_stroke_next;
            rejected_reg   <= rejected_next;
            dropped_reg    <= dropped_next;
            mode_out_reg   <= mode_next;
            count_out_reg  <= count_next;
        end
    end

    // store write at the fill count
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dev_mem[count_reg[AW-1:0]]    <= device;
            stroke_mem[count_reg[AW-1:0]] <= stroke_word;
            time_mem[count_reg[AW-1:0]]   <= tick_reg;
        end
    end

    // prefetch the entry at the next pointer and the time of the one after
    always_ff @(posedge clk)
    begin
        rd_dev      <= dev_mem[ptr_next[AW-1:0]];
        rd_stroke   <= stroke_mem[ptr_next[AW-1:0]];
        rd_time_cur <= time_mem[ptr_next[AW-1:0]];
        rd_time_nxt <= time_mem[ptr_next_inc[AW-1:0]];
    end

    // outputs
    assign count_ext       = {{COUNT_OUT_W{1'b0}}, count_out_reg};
    assign out_valid       = out_valid_reg;
    assign send_valid      = snd_valid_reg;
    assign send_source     = snd_src_reg;
    assign send_device     = snd_dev_reg;
    assign send_stroke     = snd_stroke_reg;
    assign mode            = mode_out_reg;
    assign toggle_rejected = rejected_reg;
    assign record_count    = count_ext[COUNT_OUT_W-1:0];
    assign record_dropped  = dropped_reg;

endmodule
